>>> sv/phdd_pkg.sv
// ----------------------------------------------------------------------------
// phdd_pkg
// Shared constants, register indexes and sequencer states for the
// Page-Hinkley drift detector.
// ----------------------------------------------------------------------------
package phdd_pkg;

  // default parameter values
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 40;

  // fixed register and state widths
  localparam int COUNT_W      = 32;
  localparam int MEAN_IN_W    = 16;
  localparam int HALF_JUMP_W  = 15;
  localparam int THRESH_W     = 39;
  localparam int INIT_COUNT_W = 16;
  localparam int FRAC_EXTRA   = 16;
  localparam int CFG_DATA_W   = 39;
  localparam int CFG_IDX_W    = 2;

  // register reset values
  localparam logic [MEAN_IN_W-1:0]    MEAN_RST       = 16'd0;
  localparam logic [HALF_JUMP_W-1:0]  HALF_JUMP_RST  = 15'd13;
  localparam logic [THRESH_W-1:0]     THRESH_RST     = 39'd51;
  localparam logic [INIT_COUNT_W-1:0] INIT_COUNT_RST = 16'd30;

  // bit positions of the drift code
  localparam int DRIFT_DOWN_BIT = 0;
  localparam int DRIFT_UP_BIT   = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_MEAN    = 2'd0,
    CFG_HALF_JUMP       = 2'd1,
    CFG_DRIFT_THRESHOLD = 2'd2,
    CFG_INITIAL_COUNT   = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUM,
    ST_EXT,
    ST_CMP,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

>>> sv/phdd_divider.sv
// ----------------------------------------------------------------------------
// phdd_divider
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module phdd_divider #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // trial subtraction of the shifted remainder
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> sv/page_hinkley_drift_detector_unit.sv
// ----------------------------------------------------------------------------
// page_hinkley_drift_detector_unit
// Two-sided Page-Hinkley mean-drift test on signed Q8.8 samples, with a
// running mean that follows the samples until an excursion shows up.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_ready    in_sample
//  out       out_valid/out_ready  out_drift, out_mean_estimate
//  cfg       cfg_we               cfg_index, cfg_wdata
//
//  A sample passes from its transfer through ST_STEP, ST_SUM, ST_EXT and
//  ST_CMP to ST_OUT when the mean holds, and through ST_DIV and ST_APPLY
//  as well when the mean moves: the serial divider for the mean update gives one quotient bit a
//  cycle. The next sample can transfer in the cycle after the result is loaded.
//  in_ready is high only while the sequencer is idle. A result waits in the
//  output register; a stalled output holds the sequencer in its last step.
//  Reset is synchronous; writing initial_mean or initial_count restarts.
// ----------------------------------------------------------------------------
module page_hinkley_drift_detector_unit #(
  parameter int SAMPLE_WIDTH = phdd_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = phdd_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_drift,
  output logic signed [SAMPLE_WIDTH-1:0]    out_mean_estimate,
  input  logic                              cfg_we,
  input  logic [phdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phdd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import phdd_pkg::*;

  localparam int WIDE_W = (SAMPLE_WIDTH > MEAN_IN_W) ? SAMPLE_WIDTH : MEAN_IN_W;
  localparam int MEAN_W = WIDE_W + FRAC_EXTRA;
  localparam int D_W    = WIDE_W + 2;
  localparam int SUM_W  = ((ACC_WIDTH > D_W) ? ACC_WIDTH : D_W) + 1;
  localparam int NUM_W  = ((MEAN_W > COUNT_W) ? MEAN_W : COUNT_W) + 1;
  localparam int EXC_W  = (ACC_WIDTH > THRESH_W) ? ACC_WIDTH : THRESH_W;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [WIDE_W:0] Q_MAX =
    (WIDE_W+1)'((64'd1 << (SAMPLE_WIDTH-1)) - 64'd1);
  localparam logic signed [WIDE_W:0] Q_MIN = ~Q_MAX;
  localparam logic signed [MEAN_W:0] RND_HALF = (MEAN_W+1)'(1) <<< (FRAC_EXTRA-1);

  // registers
  state_t                        state_r, state_nxt;
  logic signed [MEAN_IN_W-1:0]   cfg_mean_r, cfg_mean_nxt;
  logic [HALF_JUMP_W-1:0]        cfg_hj_r, cfg_hj_nxt;
  logic [THRESH_W-1:0]           cfg_thr_r, cfg_thr_nxt;
  logic [INIT_COUNT_W-1:0]       cfg_cnt_r, cfg_cnt_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic signed [D_W-1:0]         up_d_r, up_d_nxt;
  logic signed [D_W-1:0]         dn_d_r, dn_d_nxt;
  logic signed [ACC_WIDTH-1:0]   up_sum_r, up_sum_nxt;
  logic signed [ACC_WIDTH-1:0]   up_max_r, up_max_nxt;
  logic signed [ACC_WIDTH-1:0]   dn_sum_r, dn_sum_nxt;
  logic signed [ACC_WIDTH-1:0]   dn_min_r, dn_min_nxt;
  logic signed [MEAN_W-1:0]      mean_r, mean_nxt;
  logic [COUNT_W-1:0]            count_r, count_nxt;
  logic                          upd_r, upd_nxt;
  logic signed [MEAN_W:0]        diff_r, diff_nxt;
  logic                          neg_r, neg_nxt;
  logic [1:0]                    drift_r, drift_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_drift_r, out_drift_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_mean_r, out_mean_nxt;

  // combinational helpers
  logic signed [MEAN_W:0]        mean_rnd;
  logic signed [WIDE_W:0]        mean_sh;
  logic signed [WIDE_W:0]        mean_sat;
  logic signed [SAMPLE_WIDTH-1:0] mean_q;
  logic signed [SUM_W-1:0]       up_add;
  logic signed [SUM_W-1:0]       dn_add;
  logic [ACC_WIDTH-1:0]          down_exc;
  logic [ACC_WIDTH-1:0]          up_exc;
  logic signed [MEAN_W:0]        diff_abs;
  logic                          div_start;
  logic                          div_done;
  logic [NUM_W-1:0]              div_num;
  logic [NUM_W-1:0]              div_quot;
  logic [MEAN_W-1:0]             quo;

  // clamp a wide sum to the accumulator range
  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > SUM_W'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < SUM_W'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  // running mean rounded to Q8.8 and clamped to the sample range
  always_comb begin
    mean_rnd = (MEAN_W+1)'(mean_r) + RND_HALF;
    mean_sh  = mean_rnd[MEAN_W:FRAC_EXTRA];
    if (mean_sh > Q_MAX) begin
      mean_sat = Q_MAX;
    end else if (mean_sh < Q_MIN) begin
      mean_sat = Q_MIN;
    end else begin
      mean_sat = mean_sh;
    end
    mean_q = mean_sat[SAMPLE_WIDTH-1:0];
  end

  // shared arithmetic operands
  always_comb begin
    up_add   = SUM_W'(up_sum_r) + SUM_W'(up_d_r);
    dn_add   = SUM_W'(dn_sum_r) + SUM_W'(dn_d_r);
    down_exc = up_max_r - up_sum_r;
    up_exc   = dn_sum_r - dn_min_r;
    diff_abs = diff_r[MEAN_W] ? -diff_r : diff_r;
    div_num  = NUM_W'(diff_abs[MEAN_W-1:0]) + NUM_W'(count_r >> 1);
    quo      = div_quot[MEAN_W-1:0];
  end

  // sequencer and next values
  always_comb begin
    state_nxt     = state_r;
    cfg_mean_nxt  = cfg_mean_r;
    cfg_hj_nxt    = cfg_hj_r;
    cfg_thr_nxt   = cfg_thr_r;
    cfg_cnt_nxt   = cfg_cnt_r;
    sample_nxt    = sample_r;
    up_d_nxt      = up_d_r;
    dn_d_nxt      = dn_d_r;
    up_sum_nxt    = up_sum_r;
    up_max_nxt    = up_max_r;
    dn_sum_nxt    = dn_sum_r;
    dn_min_nxt    = dn_min_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    upd_nxt       = upd_r;
    diff_nxt      = diff_r;
    neg_nxt       = neg_r;
    drift_nxt     = drift_r;
    out_valid_nxt = out_valid_r;
    out_drift_nxt = out_drift_r;
    out_mean_nxt  = out_mean_r;
    div_start     = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    // result leaves on transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = ST_STEP;
        end
      end
      // sample minus mean, plus and minus half jump
      ST_STEP: begin
        up_d_nxt  = D_W'(sample_r) - D_W'(mean_q) + D_W'($signed({1'b0, cfg_hj_r}));
        dn_d_nxt  = D_W'(sample_r) - D_W'(mean_q) - D_W'($signed({1'b0, cfg_hj_r}));
        state_nxt = ST_SUM;
      end
      // saturating cumulative sums
      ST_SUM: begin
        up_sum_nxt = sat_acc(up_add);
        dn_sum_nxt = sat_acc(dn_add);
        state_nxt  = ST_EXT;
      end
      // extremes, count and mean difference
      ST_EXT: begin
        if (up_sum_r > up_max_r) begin
          up_max_nxt = up_sum_r;
        end
        if (dn_sum_r < dn_min_r) begin
          dn_min_nxt = dn_sum_r;
        end
        upd_nxt = (up_sum_r >= up_max_r) && (dn_sum_r <= dn_min_r);
        if (count_r != {COUNT_W{1'b1}}) begin
          count_nxt = count_r + 1'b1;
        end
        diff_nxt  = ((MEAN_W+1)'(sample_r) <<< FRAC_EXTRA) - (MEAN_W+1)'(mean_r);
        state_nxt = ST_CMP;
      end
      // threshold compare and divider launch
      ST_CMP: begin
        drift_nxt[DRIFT_DOWN_BIT] = EXC_W'(down_exc) > EXC_W'(cfg_thr_r);
        drift_nxt[DRIFT_UP_BIT]   = EXC_W'(up_exc) > EXC_W'(cfg_thr_r);
        neg_nxt = diff_r[MEAN_W];
        if (upd_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      // move the mean by the rounded quotient
      ST_APPLY: begin
        mean_nxt  = neg_r ? (mean_r - $signed(quo)) : (mean_r + $signed(quo));
        state_nxt = ST_OUT;
      end
      // load the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drift_nxt = drift_r;
          out_mean_nxt  = mean_q;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes, restart on mean or count
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INITIAL_MEAN: begin
          cfg_mean_nxt = cfg_wdata[MEAN_IN_W-1:0];
          up_sum_nxt   = '0;
          up_max_nxt   = '0;
          dn_sum_nxt   = '0;
          dn_min_nxt   = '0;
          mean_nxt     = MEAN_W'($signed(cfg_wdata[MEAN_IN_W-1:0])) <<< FRAC_EXTRA;
          count_nxt    = COUNT_W'(cfg_cnt_r);
        end
        CFG_HALF_JUMP: begin
          cfg_hj_nxt = cfg_wdata[HALF_JUMP_W-1:0];
        end
        CFG_DRIFT_THRESHOLD: begin
          cfg_thr_nxt = cfg_wdata[THRESH_W-1:0];
        end
        CFG_INITIAL_COUNT: begin
          cfg_cnt_nxt = cfg_wdata[INIT_COUNT_W-1:0];
          up_sum_nxt  = '0;
          up_max_nxt  = '0;
          dn_sum_nxt  = '0;
          dn_min_nxt  = '0;
          mean_nxt    = MEAN_W'(cfg_mean_r) <<< FRAC_EXTRA;
          count_nxt   = COUNT_W'(cfg_wdata[INIT_COUNT_W-1:0]);
        end
        default: begin
          cfg_hj_nxt = cfg_hj_r;
        end
      endcase
    end
  end

  // control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_mean_r  <= MEAN_RST;
      cfg_hj_r    <= HALF_JUMP_RST;
      cfg_thr_r   <= THRESH_RST;
      cfg_cnt_r   <= INIT_COUNT_RST;
      up_sum_r    <= '0;
      up_max_r    <= '0;
      dn_sum_r    <= '0;
      dn_min_r    <= '0;
      mean_r      <= MEAN_W'($signed(MEAN_RST)) <<< FRAC_EXTRA;
      count_r     <= COUNT_W'(INIT_COUNT_RST);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_mean_r  <= cfg_mean_nxt;
      cfg_hj_r    <= cfg_hj_nxt;
      cfg_thr_r   <= cfg_thr_nxt;
      cfg_cnt_r   <= cfg_cnt_nxt;
      up_sum_r    <= up_sum_nxt;
      up_max_r    <= up_max_nxt;
      dn_sum_r    <= dn_sum_nxt;
      dn_min_r    <= dn_min_nxt;
      mean_r      <= mean_nxt;
      count_r     <= count_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    up_d_r      <= up_d_nxt;
    dn_d_r      <= dn_d_nxt;
    upd_r       <= upd_nxt;
    diff_r      <= diff_nxt;
    neg_r       <= neg_nxt;
    drift_r     <= drift_nxt;
    out_drift_r <= out_drift_nxt;
    out_mean_r  <= out_mean_nxt;
  end

  // serial divider for the mean update
  phdd_divider #(
    .NUM_W (NUM_W),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_num),
    .denom (count_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid         = out_valid_r;
  assign out_drift         = out_drift_r;
  assign out_mean_estimate = out_mean_r;

endmodule

>>> bench/tb_page_hinkley_drift_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_hinkley_drift_detector_unit
// Self-checking bench for the Page-Hinkley drift detector. A short directed
// pass walks the register and sample extremes. Random phases follow: level
// segments with steps and outliers, under random register settings. Each
// result is checked against an in-bench predictor of the sums, the running
// mean and the drift code.
// ----------------------------------------------------------------------------
module tb_page_hinkley_drift_detector_unit;
  import phdd_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     RAND_PHASES  = 5;
  localparam int     PHASE_ITEMS  = 100;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     HOLD_AFTER   = 150;
  localparam int     TAIL_CYCLES  = 64;
  localparam int     PRINT_CAP    = 40;
  localparam longint ACC_HI       = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_LO       = -ACC_HI - 1;
  localparam longint MEAN_HI      = (longint'(1) <<< (SAMPLE_WIDTH_DEF - 1)) - 1;
  localparam longint MEAN_LO      = -MEAN_HI - 1;
  localparam longint COUNT_MAX    = (longint'(1) <<< COUNT_W) - 1;

  typedef struct {
    logic [1:0]         drift;
    logic signed [15:0] mean;
  } drift_result_t;

  // predicted detector state and the results still owed by the block
  class drift_ledger;
    logic signed [MEAN_IN_W-1:0] reg_mean;
    logic [HALF_JUMP_W-1:0]      reg_half_jump;
    logic [THRESH_W-1:0]         reg_threshold;
    logic [INIT_COUNT_W-1:0]     reg_count;
    longint up_acc, up_peak, down_acc, down_floor, mean_q824, seen;
    drift_result_t expected_flags[$];
    int n_checked, n_errors, n_down, n_up;

    function new();
      reg_mean      = MEAN_RST;
      reg_half_jump = HALF_JUMP_RST;
      reg_threshold = THRESH_RST;
      reg_count     = INIT_COUNT_RST;
      n_checked     = 0;
      n_errors      = 0;
      n_down        = 0;
      n_up          = 0;
      restart();
    endfunction

    function void restart();
      up_acc     = 0;
      up_peak    = 0;
      down_acc   = 0;
      down_floor = 0;
      mean_q824  = longint'(reg_mean) * 65536;
      seen       = longint'(reg_count);
    endfunction

    function void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_INITIAL_MEAN: begin
          reg_mean = val[MEAN_IN_W-1:0];
          restart();
        end
        CFG_HALF_JUMP: begin
          reg_half_jump = val[HALF_JUMP_W-1:0];
        end
        CFG_DRIFT_THRESHOLD: begin
          reg_threshold = val[THRESH_W-1:0];
        end
        CFG_INITIAL_COUNT: begin
          reg_count = val[INIT_COUNT_W-1:0];
          restart();
        end
        default: begin
        end
      endcase
    endfunction

    // Q8.24 mean rounded half up to Q8.8, clamped to the sample range
    function longint rounded_mean();
      longint m;
      m = (mean_q824 + 32768) >>> FRAC_EXTRA;
      if (m > MEAN_HI) m = MEAN_HI;
      if (m < MEAN_LO) m = MEAN_LO;
      return m;
    endfunction

    function longint clamp_acc(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    // fold one accepted sample into the state and queue its result
    function void note_sample(logic signed [15:0] s);
      longint smp, m, hj, thr, diff, mag, q, dn_exc, up_exc;
      drift_result_t want;
      smp = longint'(s);
      m   = rounded_mean();
      hj  = longint'(reg_half_jump);
      thr = longint'(reg_threshold);
      up_acc   = clamp_acc(up_acc + smp - m + hj);
      down_acc = clamp_acc(down_acc + smp - m - hj);
      if (up_acc > up_peak) up_peak = up_acc;
      if (down_acc < down_floor) down_floor = down_acc;
      if (seen < COUNT_MAX) seen++;
      // mean follows the samples only while both excursions are zero
      if (up_peak == up_acc && down_acc == down_floor) begin
        diff = smp * 65536 - mean_q824;
        mag  = (diff < 0) ? -diff : diff;
        q    = (mag + seen / 2) / seen;
        mean_q824 = (diff < 0) ? mean_q824 - q : mean_q824 + q;
      end
      dn_exc = up_peak - up_acc;
      up_exc = down_acc - down_floor;
      want.drift = 2'b00;
      want.drift[DRIFT_DOWN_BIT] = (dn_exc > thr);
      want.drift[DRIFT_UP_BIT]   = (up_exc > thr);
      want.mean  = 16'(rounded_mean());
      expected_flags.push_back(want);
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= PRINT_CAP) $display("mismatch @%0t: %s", $time, msg);
    endtask

    // compare one result transfer with the oldest prediction
    task check_result(logic [1:0] drift, logic signed [15:0] mean);
      drift_result_t want;
      n_checked++;
      if (drift[DRIFT_DOWN_BIT]) n_down++;
      if (drift[DRIFT_UP_BIT]) n_up++;
      if (expected_flags.size() == 0) begin
        report($sformatf("result drift=%0d mean=%0d with no sample pending", drift, mean));
      end else begin
        want = expected_flags.pop_front();
        if (drift !== want.drift)
          report($sformatf("result %0d: drift %0d, want %0d", n_checked, drift, want.drift));
        if (mean !== want.mean)
          report($sformatf("result %0d: mean %0d, want %0d", n_checked, mean, want.mean));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [15:0]            in_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_drift;
  logic signed [15:0]            out_mean_estimate;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  drift_ledger ledger = new();
  logic        gaps_on;
  logic        hold_done;
  int          hold_cnt;
  int          quiet_cycles;
  int          n_settings;
  int          seg_left, seg_level, seg_noise;

  page_hinkley_drift_detector_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drift         (out_drift),
    .out_mean_estimate (out_mean_estimate),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [15:0] s);
    if (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    ledger.note_sample(s);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.load_reg(idx, val);
    @(negedge clk);
  endtask

  // stop offering and let every owed result come out
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.expected_flags.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // random register setting; unused upper data bits carry noise
  task automatic random_settings();
    logic [THRESH_W-1:0]     thr;
    logic [HALF_JUMP_W-1:0]  hj;
    logic [INIT_COUNT_W-1:0] cnt;
    case ($urandom_range(4))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = THRESH_W'({$urandom, $urandom});
      default: thr = THRESH_W'($urandom_range(3000));
    endcase
    hj  = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(200));
    cnt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60));
    write_reg(CFG_HALF_JUMP, {24'($urandom), hj});
    write_reg(CFG_DRIFT_THRESHOLD, thr);
    write_reg(CFG_INITIAL_MEAN, {23'($urandom), 16'($urandom)});
    write_reg(CFG_INITIAL_COUNT, {23'($urandom), cnt});
  endtask

  // noisy level segments with steps, plus the odd full-range outlier
  task automatic pick_sample(output logic signed [15:0] s);
    int v;
    if (seg_left == 0) begin
      seg_left  = $urandom_range(40, 8);
      seg_noise = ($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(40);
      if ($urandom_range(3) == 0) seg_level = int'($urandom_range(65535)) - 32768;
      else seg_level = seg_level + int'($urandom_range(1200)) - 600;
    end
    seg_left--;
    if ($urandom_range(19) == 0) v = int'($urandom_range(65535)) - 32768;
    else v = seg_level + int'($urandom_range(2 * seg_noise)) - seg_noise;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    s = 16'(v);
  endtask

  // result side: random stalls, and one long hold-off while samples keep coming
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (!hold_done && ledger.n_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      end else if (gaps_on && $urandom_range(99) < 6) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(out_drift, out_mean_estimate);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results owed", QUIET_LIMIT,
                 ledger.expected_flags.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    logic signed [15:0] smp;
    int phase, k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_INITIAL_MEAN;
    cfg_wdata    = '0;
    gaps_on      = 1'b1;
    seg_left     = 0;
    seg_level    = 0;
    seg_noise    = 0;
    n_settings   = 1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero, small steps, both sample extremes
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd256);
    send_sample(-16'sd256);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    drain();

    // top mean, zero initial count, no half jump, zero threshold
    write_reg(CFG_HALF_JUMP, '0);
    write_reg(CFG_DRIFT_THRESHOLD, '0);
    write_reg(CFG_INITIAL_COUNT, '0);
    write_reg(CFG_INITIAL_MEAN, 39'h7FFF);
    n_settings++;
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    send_sample(16'sd1);
    drain();

    // bottom mean, full count, widest half jump and threshold
    write_reg(CFG_HALF_JUMP, 39'h7FFF);
    write_reg(CFG_DRIFT_THRESHOLD, '1);
    write_reg(CFG_INITIAL_COUNT, 39'hFFFF);
    write_reg(CFG_INITIAL_MEAN, 39'h8000);
    n_settings++;
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    drain();

    // initial count of one, then steps of the sample level
    write_reg(CFG_HALF_JUMP, 39'd13);
    write_reg(CFG_DRIFT_THRESHOLD, 39'd51);
    write_reg(CFG_INITIAL_COUNT, 39'd1);
    write_reg(CFG_INITIAL_MEAN, '0);
    n_settings++;
    send_sample(16'sd1000);
    send_sample(16'sd1000);
    send_sample(16'sd1001);
    send_sample(16'sd999);
    send_sample(16'sd1500);
    send_sample(16'sd1500);
    drain();

    // random phases, one of them without any idling
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      gaps_on = (phase != 2);
      random_settings();
      n_settings++;
      seg_level = int'(ledger.reg_mean);
      seg_noise = 20;
      seg_left  = 20;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick_sample(smp);
        send_sample(smp);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("checked %0d results under %0d register settings, %0d mismatches",
             ledger.n_checked, n_settings, ledger.n_errors);
    $display("downward flags %0d, upward flags %0d, receiver hold-off %0d cycles",
             ledger.n_down, ledger.n_up, hold_done ? HOLD_CYCLES : 0);
    if (ledger.n_errors == 0 && ledger.expected_flags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
